@@ rtl/pal_pkg.sv @@
// Shared widths, request and status codes for the positional array list.
package pal_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 8;
	localparam int CNT_W  = 8;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;

	localparam int CAPACITY_DEF = 128;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 56;

	localparam logic [KIND_W-1:0] REQ_GET    = 3'd0;
	localparam logic [KIND_W-1:0] REQ_LOCATE = 3'd1;
	localparam logic [KIND_W-1:0] REQ_INSERT = 3'd2;
	localparam logic [KIND_W-1:0] REQ_DELETE = 3'd3;
	localparam logic [KIND_W-1:0] REQ_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNUSED = 2'd3;

endpackage

@@ rtl/pal_mem.sv @@
// Element store: one write port, one read port with registered read data.
module pal_mem #(
	parameter int DEPTH = pal_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [pal_pkg::DATA_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [pal_pkg::DATA_W-1:0] rdata
);

	logic [pal_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [pal_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/positional_array_list.sv @@
// Positional array list: ordered list of 32-bit values, get/locate/insert/delete/clear.
// Result path: clear, unused kinds and rejected requests go straight to S_DONE; get,
//   locate and delete pass through S_RUN, insert through S_RUN and S_PUT; locate stops at
//   the first hit; insert/delete move elements one per cycle via the store port.
// Throughput: one request at a time; s_axis_tready is high only when the sequencer idles.
// Reset (arst_n low): list empty, no result pending; store contents stay undefined.
module positional_array_list #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [7:0] position, [39:8] value
	input  logic [pal_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [2:0] req_type
	input  logic [pal_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [1:0] status, [33:2] read_data, [41:34] found_position,
	// [49:42] list_length, [55:50] zero
	output logic [pal_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	localparam int AW = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,   // stream reads through the store, shift or compare
		S_PUT,   // insert: write the new value into the opened slot
		S_DONE   // hand result to the output register
	} state_t;

	state_t                       state_q;
	logic [pal_pkg::KIND_W-1:0]   op_q;
	logic [pal_pkg::POS_W-1:0]    pos_q;
	logic [pal_pkg::DATA_W-1:0]   val_q;
	logic [pal_pkg::CNT_W-1:0]    count_q;
	logic [pal_pkg::CNT_W-1:0]    reads_left_q;
	logic [AW-1:0]                rd_addr_q;
	logic                         desc_q;
	logic                         vld_s1;
	logic [AW-1:0]                addr_s1;

	// result under construction
	logic [pal_pkg::STAT_W-1:0]   status_q;
	logic [pal_pkg::DATA_W-1:0]   rdata_q;
	logic [pal_pkg::POS_W-1:0]    found_q;

	// output register
	logic                         m_valid_q;
	logic [pal_pkg::STAT_W-1:0]   o_status_q;
	logic [pal_pkg::DATA_W-1:0]   o_rdata_q;
	logic [pal_pkg::POS_W-1:0]    o_found_q;
	logic [pal_pkg::CNT_W-1:0]    o_len_q;

	// input fields
	logic [pal_pkg::KIND_W-1:0]   in_kind;
	logic [pal_pkg::POS_W-1:0]    in_pos;
	logic [pal_pkg::DATA_W-1:0]   in_val;
	logic                         accept;

	// store ports
	logic                         issue;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [pal_pkg::DATA_W-1:0]   mem_wdata;
	logic [pal_pkg::DATA_W-1:0]   mem_rdata;
	logic                         hit;

	assign in_kind = s_axis_tuser[2:0];
	assign in_pos  = s_axis_tdata[7:0];
	assign in_val  = s_axis_tdata[39:8];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// one read per cycle while reads remain
	assign issue = (state_q == S_RUN) && (reads_left_q != '0);
	assign hit   = vld_s1 && (op_q == pal_pkg::REQ_LOCATE) && (mem_rdata == val_q);

	// shift write lands in the cycle after its read; insert moves up, delete moves down
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = mem_rdata;
		if (state_q == S_RUN && vld_s1) begin
			if (op_q == pal_pkg::REQ_INSERT) begin
				mem_we    = 1'b1;
				mem_waddr = addr_s1 + AW'(1);
			end else if (op_q == pal_pkg::REQ_DELETE) begin
				mem_we    = 1'b1;
				mem_waddr = addr_s1 - AW'(1);
			end
		end else if (state_q == S_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(pos_q - 8'd1);
			mem_wdata = val_q;
		end
	end

	pal_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			reads_left_q <= '0;
			vld_s1       <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q         <= in_kind;
						pos_q        <= in_pos;
						val_q        <= in_val;
						status_q     <= pal_pkg::ST_OK;
						rdata_q      <= '0;
						found_q      <= '0;
						reads_left_q <= '0;
						vld_s1       <= 1'b0;
						desc_q       <= 1'b0;
						rd_addr_q    <= '0;
						state_q      <= S_DONE;
						case (in_kind)
							pal_pkg::REQ_GET: begin
								if (in_pos == '0 || in_pos > count_q) begin
									status_q <= pal_pkg::ST_BADPOS;
								end else begin
									reads_left_q <= 8'd1;
									rd_addr_q    <= AW'(in_pos - 8'd1);
									state_q      <= S_RUN;
								end
							end
							pal_pkg::REQ_LOCATE: begin
								reads_left_q <= count_q;
								state_q      <= S_RUN;
							end
							pal_pkg::REQ_INSERT: begin
								if (in_pos == '0 ||
								    {1'b0, in_pos} > ({1'b0, count_q} + 9'd1)) begin
									status_q <= pal_pkg::ST_BADPOS;
								end else if (count_q >= pal_pkg::CNT_W'(CAPACITY)) begin
									status_q <= pal_pkg::ST_FULL;
								end else begin
									// walk from the tail down to the slot
									reads_left_q <= count_q - in_pos + 8'd1;
									rd_addr_q    <= AW'(count_q - 8'd1);
									desc_q       <= 1'b1;
									state_q      <= S_RUN;
								end
							end
							pal_pkg::REQ_DELETE: begin
								if (in_pos == '0 || in_pos > count_q) begin
									status_q <= pal_pkg::ST_BADPOS;
								end else begin
									reads_left_q <= count_q - in_pos;
									rd_addr_q    <= AW'(in_pos);
									state_q      <= S_RUN;
								end
							end
							pal_pkg::REQ_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end

				S_RUN: begin
					vld_s1  <= issue;
					addr_s1 <= rd_addr_q;
					if (issue) begin
						reads_left_q <= reads_left_q - 8'd1;
						rd_addr_q    <= desc_q ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
					end
					if (vld_s1 && op_q == pal_pkg::REQ_GET) begin
						rdata_q <= mem_rdata;
					end
					if (hit) begin
						// first match wins; drop any read in flight
						found_q      <= pal_pkg::POS_W'(addr_s1) + 8'd1;
						reads_left_q <= '0;
						vld_s1       <= 1'b0;
						state_q      <= S_DONE;
					end else if (reads_left_q == '0 && !vld_s1) begin
						if (op_q == pal_pkg::REQ_INSERT) begin
							state_q <= S_PUT;
						end else begin
							if (op_q == pal_pkg::REQ_DELETE) begin
								count_q <= count_q - 8'd1;
							end
							state_q <= S_DONE;
						end
					end
				end

				S_PUT: begin
					count_q <= count_q + 8'd1;
					state_q <= S_DONE;
				end

				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q  <= 1'b1;
						o_status_q <= status_q;
						o_rdata_q  <= rdata_q;
						o_found_q  <= found_q;
						o_len_q    <= count_q;
						state_q    <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, o_len_q, o_found_q, o_rdata_q, o_status_q};

endmodule

@@ rtl/pal_chk.sv @@
// Port-level checker for the positional array list, bound to the top level.
module pal_chk #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [pal_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	// a pending result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or dropped while stalled");

	// one request at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready straight after a transfer");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[49:42] <= pal_pkg::CNT_W'(CAPACITY))
		else $error("length above capacity");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != pal_pkg::ST_UNUSED)
		else $error("unused status code");

	// full is only reported on a full list
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == pal_pkg::ST_FULL
		|-> m_axis_tdata[49:42] == pal_pkg::CNT_W'(CAPACITY))
		else $error("full status with room left");

endmodule

bind positional_array_list pal_chk #(
	.CAPACITY (CAPACITY)
) u_pal_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
